FILE: src/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
// Used by every module under src except sem_ram; no dependencies of its own.
package sem_pkg;

	// Pixel and size fields
	localparam int PIX_W      = 8;
	localparam int DIM_W      = 11;
	localparam int DIM_MIN    = 3;
	localparam int DIM_RESET  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int ROW_W      = 10;
	localparam int MAX_WIDTH_DEF = 1024;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// Gradient and magnitude
	localparam int GRAD_W     = 11;
	localparam int SQ_W       = 2 * GRAD_W;
	localparam int RAD_W      = 16;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

	// Gradient pair handed from the window stage to the magnitude pipeline
	typedef struct packed {
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
		logic                     last;
	} grad_t;

endpackage

FILE: src/sem_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sem_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/sem_window.sv
// Raster position tracking, line-buffer RAM and 3x3 window with Sobel gradients.
// Depends on sem_pkg and sem_ram.
module sem_window #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sem_pkg::DIM_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sem_pkg::PIX_W-1:0]     pixel,
	output logic                          grad_valid,
	input  logic                          grad_ready,
	output sem_pkg::grad_t                grad
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int XW = ((CW > sem_pkg::DIM_W) ? CW : sem_pkg::DIM_W) + 1;
	localparam int RW = sem_pkg::ROW_W;
	localparam int PW = sem_pkg::PIX_W;
	localparam logic [CW-1:0] WMAX_RST =
		CW'(((MAX_WIDTH < sem_pkg::DIM_RESET) ? MAX_WIDTH : sem_pkg::DIM_RESET) - 1);
	localparam logic [RW-1:0] HMAX_RST = RW'(sem_pkg::DIM_RESET - 1);

	logic [CW-1:0] wmax_q, wmax_d, col_q;
	logic [RW-1:0] hmax_q, hmax_d, row_q;
	logic [XW-1:0] cfg_x;
	logic          in_fire;

	logic          valid_s1, int_s1, last_s1, adv_s1;
	logic [PW-1:0] pix_s1;
	logic [CW-1:0] col_s1;
	logic [2*PW-1:0] ram_rdata;
	logic [PW-1:0] top, mid, bot;
	logic [PW-1:0] win_q [6];

	logic [PW+1:0] sum_r, sum_l, sum_t, sum_b;
	logic signed [sem_pkg::GRAD_W-1:0] gx, gy;
	logic          ld_s2, grad_valid_q;
	sem_pkg::grad_t grad_q;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid & in_ready;

	// Clamp written sizes to their legal range, stored as last index
	always_comb begin
		cfg_x = XW'(cfg_data);
		if (cfg_x < XW'(sem_pkg::DIM_MIN)) begin
			wmax_d = CW'(sem_pkg::DIM_MIN - 1);
		end else if (cfg_x > XW'(MAX_WIDTH)) begin
			wmax_d = CW'(MAX_WIDTH - 1);
		end else begin
			wmax_d = CW'(cfg_x - XW'(1));
		end
		if (cfg_data < sem_pkg::DIM_W'(sem_pkg::DIM_MIN)) begin
			hmax_d = RW'(sem_pkg::DIM_MIN - 1);
		end else if (cfg_data > sem_pkg::DIM_W'(sem_pkg::MAX_HEIGHT)) begin
			hmax_d = RW'(sem_pkg::MAX_HEIGHT - 1);
		end else begin
			hmax_d = RW'(cfg_data - sem_pkg::DIM_W'(1));
		end
	end

	// Size registers and raster counters; a size write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wmax_q <= WMAX_RST;
			hmax_q <= HMAX_RST;
			col_q  <= '0;
			row_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				sem_pkg::REG_IMAGE_WIDTH: begin
					wmax_q <= wmax_d;
					col_q  <= '0;
					row_q  <= '0;
				end
				sem_pkg::REG_IMAGE_HEIGHT: begin
					hmax_q <= hmax_d;
					col_q  <= '0;
					row_q  <= '0;
				end
				default: ;
			endcase
		end else if (in_fire) begin
			if (col_q == wmax_q) begin
				col_q <= '0;
				row_q <= (row_q == hmax_q) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage 1: RAM read in flight; drop border pixels once written back
	assign ld_s2    = ~grad_valid_q | grad_ready;
	assign adv_s1   = valid_s1 & (~int_s1 | ld_s2);
	assign in_ready = ~valid_s1 | adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_s1  <= pixel;
			col_s1  <= col_q;
			int_s1  <= (row_q >= RW'(2)) && (col_q >= CW'(2));
			last_s1 <= (row_q == hmax_q) && (col_q == wmax_q);
		end
	end

	// Two rows per entry: upper byte is the older row
	sem_ram #(
		.WIDTH (2 * PW),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (col_s1),
		.wdata ({mid, bot}),
		.re    (in_fire),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	assign top = ram_rdata[2*PW-1:PW];
	assign mid = ram_rdata[PW-1:0];
	assign bot = pix_s1;

	// Window: entries 0..2 are the oldest column, 3..5 the next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= bot;
		end
	end

	// Sobel gradients over the 3x3 neighborhood
	always_comb begin
		sum_r = {2'b0, top} + {1'b0, mid, 1'b0} + {2'b0, bot};
		sum_l = {2'b0, win_q[0]} + {1'b0, win_q[1], 1'b0} + {2'b0, win_q[2]};
		sum_b = {2'b0, win_q[2]} + {1'b0, win_q[5], 1'b0} + {2'b0, bot};
		sum_t = {2'b0, win_q[0]} + {1'b0, win_q[3], 1'b0} + {2'b0, top};
		gx    = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
		gy    = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
	end

	// Stage 2: gradient output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grad_valid_q <= 1'b0;
		end else if (ld_s2) begin
			grad_valid_q <= valid_s1 & int_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2 && valid_s1 && int_s1) begin
			grad_q.gx   <= gx;
			grad_q.gy   <= gy;
			grad_q.last <= last_s1;
		end
	end

	assign grad_valid = grad_valid_q;
	assign grad       = grad_q;

`ifndef SYNTHESIS
	// Read and write-back never hit the same line entry in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && adv_s1) |-> (col_q != col_s1))
		else $error("line RAM read and write to the same entry");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= wmax_q)
		else $error("column counter past last column");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= hmax_q)
		else $error("row counter past last row");
`endif

endmodule

FILE: src/sem_mag.sv
// Gradient magnitude pipeline: squares, sum with saturation, 8-step square root.
// Depends on sem_pkg.
module sem_mag (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      grad_valid,
	output logic                      grad_ready,
	input  sem_pkg::grad_t            grad,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [sem_pkg::PIX_W-1:0] edge_magnitude,
	output logic                      last_of_frame
);

	localparam int GW = sem_pkg::GRAD_W;
	localparam int QW = sem_pkg::SQ_W;
	localparam int AW = sem_pkg::RAD_W;
	localparam int TW = sem_pkg::ROOT_W;
	localparam int MW = sem_pkg::REM_W;
	localparam int NSTEP = TW;

	logic [GW-1:0] ax, ay;
	logic [QW-1:0] sqx, sqy;
	logic [QW:0]   sum;

	logic          vld_s1, vld_s2, ld_s1, ld_s2;
	logic [QW-1:0] sq_x_s1, sq_y_s1;
	logic          last_s1, last_s2, sat_s2;
	logic [AW-1:0] rad_s2;

	logic [NSTEP-1:0] step_vld_q;
	logic [NSTEP:0]   step_ld;
	logic [AW-1:0] step_rad_q  [NSTEP];
	logic [MW-1:0] step_rem_q  [NSTEP];
	logic [TW-1:0] step_root_q [NSTEP];
	logic          step_sat_q  [NSTEP];
	logic          step_last_q [NSTEP];

	// Elastic ready chain from the output back to the input
	assign step_ld[NSTEP] = out_ready;
	for (genvar k = 0; k < NSTEP; k++) begin : g_ld
		assign step_ld[k] = ~step_vld_q[k] | step_ld[k+1];
	end
	assign ld_s2      = ~vld_s2 | step_ld[0];
	assign ld_s1      = ~vld_s1 | ld_s2;
	assign grad_ready = ld_s1;

	// Stage 1: absolute values and squares
	always_comb begin
		ax  = grad.gx[GW-1] ? GW'(-grad.gx) : GW'(grad.gx);
		ay  = grad.gy[GW-1] ? GW'(-grad.gy) : GW'(grad.gy);
		sqx = QW'(ax) * QW'(ax);
		sqy = QW'(ay) * QW'(ay);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ld_s1) begin
			vld_s1 <= grad_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && grad_valid) begin
			sq_x_s1 <= sqx;
			sq_y_s1 <= sqy;
			last_s1 <= grad.last;
		end
	end

	// Stage 2: sum of squares, saturate when it needs more than 16 bits
	assign sum = {1'b0, sq_x_s1} + {1'b0, sq_y_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (ld_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2 && vld_s1) begin
			rad_s2  <= sum[AW-1:0];
			sat_s2  <= |sum[QW:AW];
			last_s2 <= last_s1;
		end
	end

	// Square root: one result bit per step, restoring remainder method
	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		logic          p_vld, p_sat, p_last, ge;
		logic [AW-1:0] p_rad;
		logic [MW-1:0] p_rem;
		logic [TW-1:0] p_root;
		logic [MW+1:0] r4, trial;

		if (k == 0) begin : g_first
			assign p_vld  = vld_s2;
			assign p_rad  = rad_s2;
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_sat  = sat_s2;
			assign p_last = last_s2;
		end else begin : g_next
			assign p_vld  = step_vld_q[k-1];
			assign p_rad  = step_rad_q[k-1];
			assign p_rem  = step_rem_q[k-1];
			assign p_root = step_root_q[k-1];
			assign p_sat  = step_sat_q[k-1];
			assign p_last = step_last_q[k-1];
		end

		assign r4    = {p_rem, p_rad[AW-1:AW-2]};
		assign trial = {2'b00, p_root, 2'b01};
		assign ge    = (r4 >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				step_vld_q[k] <= 1'b0;
			end else if (step_ld[k]) begin
				step_vld_q[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (step_ld[k] && p_vld) begin
				step_rad_q[k]  <= {p_rad[AW-3:0], 2'b00};
				step_rem_q[k]  <= ge ? MW'(r4 - trial) : MW'(r4);
				step_root_q[k] <= {p_root[TW-2:0], ge};
				step_sat_q[k]  <= p_sat;
				step_last_q[k] <= p_last;
			end
		end
	end

	// The final step register is the output register
	assign out_valid      = step_vld_q[NSTEP-1];
	assign edge_magnitude = step_sat_q[NSTEP-1] ? sem_pkg::MAG_MAX : step_root_q[NSTEP-1];
	assign last_of_frame  = step_last_q[NSTEP-1];

`ifndef SYNTHESIS
	// A finished root leaves a remainder of at most twice the root
	a_root_rem: assert property (@(posedge clk) disable iff (!arst_n)
		step_vld_q[NSTEP-1] |->
			(step_rem_q[NSTEP-1] <= {1'b0, step_root_q[NSTEP-1], 1'b0}))
		else $error("square root remainder out of range");
`endif

endmodule

FILE: src/sobel_edge_magnitude_top.sv
// Throughput: one pixel per clock unless the output stalls, set by the line RAM
// (one read, one write per cycle) and the 8-step pipelined square root; border
// pixels produce no result.
// Reset (async, active low): sizes 1024x1024, counters and window cleared; line RAM
// is not cleared, the first two rows of each frame fill it before any result uses it.
// Depends on sem_pkg, sem_window, sem_mag.
module sobel_edge_magnitude_top #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sem_pkg::DIM_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sem_pkg::PIX_W-1:0]     pixel,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sem_pkg::PIX_W-1:0]     edge_magnitude,
	output logic                          last_of_frame
);

	logic           grad_valid, grad_ready;
	sem_pkg::grad_t grad;

	sem_window #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel      (pixel),
		.grad_valid (grad_valid),
		.grad_ready (grad_ready),
		.grad       (grad)
	);

	sem_mag u_mag (
		.clk            (clk),
		.arst_n         (arst_n),
		.grad_valid     (grad_valid),
		.grad_ready     (grad_ready),
		.grad           (grad),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.edge_magnitude (edge_magnitude),
		.last_of_frame  (last_of_frame)
	);

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sobel_edge_magnitude_top: streams pixels, predicts each result.
// Depends on sem_pkg and the RTL under src only.
module tb;

	localparam int MAX_W         = sem_pkg::MAX_WIDTH_DEF;
	localparam int IMG_W         = 9 * sem_pkg::PIX_W;
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 600;
	localparam int MAG_SAT       = 255;
	localparam int SQ_SAT        = 65536;

	// Indexes with no register behind them; writes there change nothing
	localparam logic [sem_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [sem_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef enum int {PAT_NOISE, PAT_FLAT, PAT_RAMP, PAT_BINARY, PAT_SOFT} pattern_t;

	typedef struct packed {
		logic [sem_pkg::PIX_W-1:0] mag;
		logic                      last;
	} edge_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [sem_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [sem_pkg::DIM_W-1:0]     cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [sem_pkg::PIX_W-1:0]     pixel;
	logic                          out_valid;
	logic                          out_ready;
	logic [sem_pkg::PIX_W-1:0]     edge_magnitude;
	logic                          last_of_frame;

	// Predictor state
	logic [sem_pkg::DIM_W-1:0] width_reg;
	logic [sem_pkg::DIM_W-1:0] height_reg;
	logic [sem_pkg::PIX_W-1:0] line_mem [0:2*MAX_W-1];
	logic [sem_pkg::PIX_W-1:0] win_mem [0:5];
	int                        col_pos;
	int                        row_pos;
	edge_result_t              pending_edges[$];
	edge_result_t              want;

	// Traffic control and bookkeeping
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int quiet_cycles;
	int mismatches;
	int pixels_sent;
	int results_seen;
	int frame_ends;
	int cfg_writes;

	sobel_edge_magnitude_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pixel          (pixel),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.edge_magnitude (edge_magnitude),
		.last_of_frame  (last_of_frame)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Size register as the block uses it
	function automatic int fit_size(input int v, input int hi);
		if (v < sem_pkg::DIM_MIN)
			return sem_pkg::DIM_MIN;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int floor_root(input int s);
		int root;
		root = 0;
		while ((root + 1) * (root + 1) <= s)
			root++;
		return root;
	endfunction

	task automatic model_reset();
		int k;
		width_reg  = sem_pkg::DIM_W'(sem_pkg::DIM_RESET);
		height_reg = sem_pkg::DIM_W'(sem_pkg::DIM_RESET);
		for (k = 0; k < 2 * MAX_W; k++)
			line_mem[k] = '0;
		for (k = 0; k < 6; k++)
			win_mem[k] = '0;
		col_pos = 0;
		row_pos = 0;
	endtask

	// One pixel into the predictor: queue its edge result if it closes an interior window
	task automatic predict_edge(input logic [sem_pkg::PIX_W-1:0] px);
		int w, h, c, r, gx, gy, sq, mag;
		int t, m, b, n0, n1, n2, n3, n5;
		edge_result_t e;
		w = fit_size(int'(width_reg), MAX_W);
		h = fit_size(int'(height_reg), sem_pkg::MAX_HEIGHT);
		c = col_pos;
		r = row_pos;
		if (c >= w)
			c = 0;
		if (r >= h)
			r = 0;
		t  = int'(line_mem[c]);
		m  = int'(line_mem[MAX_W + c]);
		b  = int'(px);
		n0 = int'(win_mem[0]);
		n1 = int'(win_mem[1]);
		n2 = int'(win_mem[2]);
		n3 = int'(win_mem[3]);
		n5 = int'(win_mem[5]);
		if (r >= 2 && c >= 2) begin
			gx  = (t + 2 * m + b) - (n0 + 2 * n1 + n2);
			gy  = (n2 + 2 * n5 + b) - (n0 + 2 * n3 + t);
			sq  = gx * gx + gy * gy;
			mag = (sq >= SQ_SAT) ? MAG_SAT : floor_root(sq);
			e.mag  = mag[sem_pkg::PIX_W-1:0];
			e.last = (r == h - 1) && (c == w - 1);
			pending_edges.push_back(e);
		end
		// slide the window and roll the two line buffers
		win_mem[0] = win_mem[3];
		win_mem[1] = win_mem[4];
		win_mem[2] = win_mem[5];
		win_mem[3] = t[sem_pkg::PIX_W-1:0];
		win_mem[4] = m[sem_pkg::PIX_W-1:0];
		win_mem[5] = px;
		line_mem[c]         = m[sem_pkg::PIX_W-1:0];
		line_mem[MAX_W + c] = px;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	function automatic logic [sem_pkg::PIX_W-1:0] pattern_pixel(input pattern_t style,
			input int col, input int base, input int step);
		int v;
		case (style)
			PAT_FLAT: begin
				return base[sem_pkg::PIX_W-1:0];
			end
			PAT_RAMP: begin
				v = base + col * step;
				return v[sem_pkg::PIX_W-1:0];
			end
			PAT_BINARY: begin
				return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
			end
			PAT_SOFT: begin
				v = base + $urandom_range(15);
				return (v > MAG_SAT) ? 8'hFF : v[sem_pkg::PIX_W-1:0];
			end
			default: begin
				v = $urandom_range(255);
				return v[sem_pkg::PIX_W-1:0];
			end
		endcase
	endfunction

	// Pixel transfer; valid is left high so back-to-back pixels keep it up
	task automatic send_pixel(input logic [sem_pkg::PIX_W-1:0] px);
		cfg_valid <= 1'b0;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		pixel    <= px;
		do @(posedge clk); while (!in_ready);
		predict_edge(px);
		pixels_sent++;
	endtask

	// Register transfer; a write restarts the frame, spare indexes do nothing
	task automatic write_reg(input logic [sem_pkg::CFG_IDX_W-1:0] idx,
			input logic [sem_pkg::DIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == sem_pkg::REG_IMAGE_WIDTH) begin
			width_reg = val;
			col_pos   = 0;
			row_pos   = 0;
		end else if (idx == sem_pkg::REG_IMAGE_HEIGHT) begin
			height_reg = val;
			col_pos    = 0;
			row_pos    = 0;
		end
		cfg_writes++;
	endtask

	// Drain every pending result, then let border pixels clear the pipeline
	task automatic wait_idle();
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_edges.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_frame3(input logic [IMG_W-1:0] img);
		int k;
		for (k = 0; k < 9; k++)
			send_pixel(img[IMG_W-1 - sem_pkg::PIX_W*k -: sem_pkg::PIX_W]);
	endtask

	task automatic send_noise(input int n);
		int k;
		for (k = 0; k < n; k++)
			send_pixel(pattern_pixel(PAT_NOISE, 0, 0, 0));
	endtask

	// Reset sizes: 1024 wide, so a short run stays in the first row and gives no result
	task automatic test_reset_size();
		send_noise(40);
	endtask

	// Smallest frame: saturated gradients both ways, flat field, small gradient, mixed ramp, random
	task automatic test_min_frame();
		logic [IMG_W-1:0] img;
		wait_idle();
		write_reg(sem_pkg::REG_IMAGE_WIDTH, 11'd3);
		write_reg(sem_pkg::REG_IMAGE_HEIGHT, 11'd3);
		send_frame3({3{8'd0, 8'd128, 8'd255}});
		send_frame3({9{8'd255}});
		send_frame3({{3{8'd255}}, {6{8'd0}}});
		send_frame3({3{8'd0, 8'd0, 8'd10}});
		send_frame3({8'd0, 8'd40, 8'd90, 8'd30, 8'd70, 8'd140, 8'd60, 8'd120, 8'd200});
		img = IMG_W'({$urandom, $urandom, $urandom});
		send_frame3(img);
	endtask

	// Sizes below the minimum clamp to 3
	task automatic test_clamped_sizes();
		logic [IMG_W-1:0] img;
		wait_idle();
		write_reg(sem_pkg::REG_IMAGE_WIDTH, 11'd0);
		write_reg(sem_pkg::REG_IMAGE_HEIGHT, 11'd1);
		send_frame3({8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255});
		wait_idle();
		write_reg(sem_pkg::REG_IMAGE_WIDTH, 11'd2);
		write_reg(sem_pkg::REG_IMAGE_HEIGHT, 11'd2);
		img = IMG_W'({$urandom, $urandom, $urandom});
		send_frame3(img);
		wait_idle();
		write_reg(sem_pkg::REG_IMAGE_HEIGHT, 11'd0);
		write_reg(sem_pkg::REG_IMAGE_WIDTH, 11'd1);
		img = IMG_W'({$urandom, $urandom, $urandom});
		send_frame3(img);
	endtask

	// Writes restart the frame mid-way; spare indexes must not
	task automatic test_restart();
		wait_idle();
		write_reg(sem_pkg::REG_IMAGE_WIDTH, sem_pkg::DIM_W'(sem_pkg::DIM_RESET));
		write_reg(sem_pkg::REG_IMAGE_HEIGHT, sem_pkg::DIM_W'(sem_pkg::DIM_RESET));
		send_noise(20);
		wait_idle();
		write_reg(sem_pkg::REG_IMAGE_WIDTH, 11'd5);
		write_reg(sem_pkg::REG_IMAGE_HEIGHT, 11'd4);
		send_noise(13);
		wait_idle();
		write_reg(REG_SPARE_2, 11'd2047);
		send_noise(15);
		wait_idle();
		write_reg(sem_pkg::REG_IMAGE_HEIGHT, 11'd4);
		write_reg(REG_SPARE_3, 11'd0);
		send_noise(20);
	endtask

	// Over-range width clamps to the line length (first row only), then tallest frame
	task automatic test_widest();
		wait_idle();
		write_reg(sem_pkg::REG_IMAGE_WIDTH, 11'd2047);
		write_reg(sem_pkg::REG_IMAGE_HEIGHT, 11'd3);
		send_noise(100);
		wait_idle();
		write_reg(sem_pkg::REG_IMAGE_WIDTH, 11'd3);
		write_reg(sem_pkg::REG_IMAGE_HEIGHT, 11'd2047);
		send_noise(90);
	endtask

	// Output held off long enough to fill the pipeline and stall the input
	task automatic test_backpressure();
		wait_idle();
		write_reg(sem_pkg::REG_IMAGE_WIDTH, 11'd16);
		write_reg(sem_pkg::REG_IMAGE_HEIGHT, 11'd12);
		hold_left = HOLD_CYCLES;
		send_noise(16 * 12);
	endtask

	// Random frames, mostly small, with partial frames and mid-frame reconfiguration
	task automatic test_random_frames(input int budget);
		int goal, pick, sel, w, h, n, k, base, step;
		logic [sem_pkg::DIM_W-1:0] wv, hv;
		pattern_t style;
		goal = pixels_sent + budget;
		while (pixels_sent < goal) begin
			pick = $urandom_range(9);
			if (pick < 7) begin
				sel = $urandom_range(9);
				if (sel < 6)
					wv = sem_pkg::DIM_W'($urandom_range(16, 3));
				else if (sel < 8)
					wv = sem_pkg::DIM_W'($urandom_range(32, 17));
				else
					wv = sem_pkg::DIM_W'($urandom_range(2, 0));
				sel = $urandom_range(9);
				if (sel < 7)
					hv = sem_pkg::DIM_W'($urandom_range(8, 3));
				else if (sel < 9)
					hv = sem_pkg::DIM_W'($urandom_range(2, 0));
				else
					hv = sem_pkg::DIM_W'($urandom_range(2047, sem_pkg::MAX_HEIGHT + 1));
				wait_idle();
				if (pick != 5)
					write_reg(sem_pkg::REG_IMAGE_WIDTH, wv);
				if (pick != 6)
					write_reg(sem_pkg::REG_IMAGE_HEIGHT, hv);
			end
			w = fit_size(int'(width_reg), MAX_W);
			h = fit_size(int'(height_reg), sem_pkg::MAX_HEIGHT);
			if (h >= sem_pkg::MAX_HEIGHT)
				n = w * $urandom_range(8, 3);
			else
				n = w * h * $urandom_range(2, 1);
			if ($urandom_range(3) == 0)
				n = $urandom_range(n, 1);
			if (n > goal - pixels_sent)
				n = goal - pixels_sent;
			style = pattern_t'($urandom_range(PAT_SOFT));
			base  = $urandom_range(255);
			step  = $urandom_range(40);
			for (k = 0; k < n; k++)
				send_pixel(pattern_pixel(style, k % w, base, step));
		end
	endtask

	// Receiver: random stalls, or a counted hold-off when one is requested
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Result check against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_edges.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual mag %0d last %0b",
					$time, edge_magnitude, last_of_frame);
				mismatches++;
			end else begin
				want = pending_edges.pop_front();
				results_seen++;
				if (edge_magnitude !== want.mag) begin
					$display("%0t: edge_magnitude expected %0d, actual %0d",
						$time, want.mag, edge_magnitude);
					mismatches++;
				end
				if (last_of_frame !== want.last) begin
					$display("%0t: last_of_frame expected %0b, actual %0b",
						$time, want.last, last_of_frame);
					mismatches++;
				end else if (want.last) begin
					frame_ends++;
				end
			end
		end
	end

	// Watchdog: too long without any transfer ends the run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results pending",
				$time, STALL_LIMIT, pending_edges.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		pixel         = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left     = 0;
		quiet_cycles  = 0;
		mismatches    = 0;
		pixels_sent   = 0;
		results_seen  = 0;
		frame_ends    = 0;
		cfg_writes    = 0;
		model_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender sparse, receiver sparser
		send_idle_pct = 38;
		recv_idle_pct = 66;
		test_reset_size();
		test_min_frame();
		test_clamped_sizes();
		test_restart();
		test_random_frames(193);

		// roles swapped
		send_idle_pct = 66;
		recv_idle_pct = 38;
		test_widest();
		test_random_frames(193);

		// full rate
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random_frames(193);

		wait_idle();
		if (pending_edges.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_edges.size());
			mismatches++;
		end
		$display("Run: %0d pixels, %0d edge results (%0d frame ends), %0d register writes.",
			pixels_sent, results_seen, frame_ends, cfg_writes);
		$display("Frames from 3x3 up, clamped sizes, restarts, random sizes, %0d-cycle hold.",
			HOLD_CYCLES);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: files.f
src/sem_pkg.sv
src/sem_ram.sv
src/sem_window.sv
src/sem_mag.sv
src/sobel_edge_magnitude_top.sv
tb/sv/tb.sv
